/* rtl/core/ffrc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffrc_pkg: shared types and constants
// request codes, statistics indexes, word layouts and controller types
// ----------------------------------------------------------------------------
package ffrc_pkg;

	localparam int QUEUE_SLOTS_DEF     = 32;
	localparam int MAX_FRAME_BYTES_DEF = 32;
	localparam int RECORD_BYTES_DEF    = 34;

	localparam int NUM_STATS = 6;
	localparam int STAT_W    = 32;

	typedef enum logic [2:0] {
		REQ_PUBLISH     = 3'd0,
		REQ_READ_START  = 3'd1,
		REQ_READ_BYTE   = 3'd2,
		REQ_READ_DONE   = 3'd3,
		REQ_BUS_ERROR   = 3'd4,
		REQ_WRITE_START = 3'd5,
		REQ_WRITE_DONE  = 3'd6,
		REQ_STAT_QUERY  = 3'd7
	} req_code_t;

	localparam logic [2:0] STAT_PUBLISHED   = 3'd0;
	localparam logic [2:0] STAT_DROPPED     = 3'd1;
	localparam logic [2:0] STAT_READ_REQ    = 3'd2;
	localparam logic [2:0] STAT_READ_FRAMES = 3'd3;
	localparam logic [2:0] STAT_BUS_ERR     = 3'd4;
	localparam logic [2:0] STAT_CMD_WRITES  = 3'd5;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] data_byte;
		logic       frame_last;
		logic       ack_failure;
		logic       other_failure;
		logic [2:0] stat_select;
	} req_t;

	typedef struct packed {
		logic [7:0]  tx_byte;
		logic [4:0]  queue_level;
		logic        frame_accepted;
		logic        frame_dropped;
		logic        frame_consumed;
		logic        read_pending;
		logic [31:0] stat_value;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic lookup;
		logic commit;
	} cmd_t;

endpackage
`default_nettype wire

/* rtl/core/ffrc_chan_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffrc_chan_if: valid/ready channel
// carries one word per accepted handshake
// ----------------------------------------------------------------------------
interface ffrc_chan_if #(
	parameter type PAYLOAD_T = logic
);
	logic     valid;
	logic     ready;
	PAYLOAD_T payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/core/ffrc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffrc_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ffrc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

/* rtl/core/ffrc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffrc_ctrl: sequencing controller
// steps each word through capture, memory lookup and commit
// ----------------------------------------------------------------------------
module ffrc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	output ffrc_pkg::cmd_t      cmd
);
	ffrc_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             slot_free;

	// result register can take a new word this cycle
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffrc_pkg::ST_IDLE:   if (in_valid) state_d = ffrc_pkg::ST_LOOKUP;
			ffrc_pkg::ST_LOOKUP: state_d = ffrc_pkg::ST_COMMIT;
			ffrc_pkg::ST_COMMIT: if (slot_free) state_d = ffrc_pkg::ST_IDLE;
			default:             state_d = ffrc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.lookup  = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			ffrc_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ffrc_pkg::ST_LOOKUP: cmd.lookup = 1'b1;
			ffrc_pkg::ST_COMMIT: cmd.commit = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffrc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

/* rtl/core/ffrc_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffrc_dpath: frame ring datapath
// ring indexes, record state, statistics, frame and length memories
// ----------------------------------------------------------------------------
module ffrc_dpath #(
	parameter int QUEUE_SLOTS     = ffrc_pkg::QUEUE_SLOTS_DEF,
	parameter int MAX_FRAME_BYTES = ffrc_pkg::MAX_FRAME_BYTES_DEF,
	parameter int RECORD_BYTES    = ffrc_pkg::RECORD_BYTES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ffrc_pkg::cmd_t cmd,
	input  wire ffrc_pkg::req_t req_in,
	output ffrc_pkg::rsp_t      rsp_out
);
	localparam int SLOT_W   = $clog2(QUEUE_SLOTS);
	localparam int LEN_W    = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES + 1) : 1;
	localparam int FILL_W   = $clog2(MAX_FRAME_BYTES + 2);
	localparam int SENT_W   = $clog2(RECORD_BYTES + 1);
	localparam int STORE_D  = QUEUE_SLOTS * MAX_FRAME_BYTES;
	localparam int STORE_AW = (STORE_D > 1) ? $clog2(STORE_D) : 1;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_SLOTS - 1);
	localparam logic [FILL_W-1:0] MFB_FILL  = FILL_W'(MAX_FRAME_BYTES);
	localparam logic [SENT_W-1:0] RB_SENT   = SENT_W'(RECORD_BYTES);

	function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
		slot_next = (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
	endfunction

	function automatic logic [SLOT_W-1:0] occupancy(input logic [SLOT_W-1:0] t,
			input logic [SLOT_W-1:0] h);
		logic [SLOT_W:0] sum;
		sum = {1'b0, t} + (SLOT_W + 1)'(QUEUE_SLOTS) - {1'b0, h};
		if (sum >= (SLOT_W + 1)'(QUEUE_SLOTS)) begin
			sum = sum - (SLOT_W + 1)'(QUEUE_SLOTS);
		end
		occupancy = sum[SLOT_W-1:0];
	endfunction

	ffrc_pkg::req_t              req_q;
	logic [SLOT_W-1:0]           head_q, head_d;
	logic [SLOT_W-1:0]           tail_q, tail_d;
	logic [FILL_W-1:0]           fill_q, fill_d;
	logic                        pending_q, pending_d;
	logic [LEN_W-1:0]            rec_len_q, rec_len_d;
	logic [SLOT_W-1:0]           rec_cnt_q, rec_cnt_d;
	logic [SENT_W-1:0]           sent_q, sent_d;
	logic [ffrc_pkg::STAT_W-1:0] stats_q [ffrc_pkg::NUM_STATS];
	logic [ffrc_pkg::NUM_STATS-1:0] stat_inc;
	ffrc_pkg::rsp_t              rsp_q, rsp_d;

	logic [SENT_W-1:0]   rd_off;
	logic [STORE_AW-1:0] store_raddr, store_waddr;
	logic                store_we, len_we;
	logic [7:0]          store_rdata;
	logic [LEN_W-1:0]    len_rdata, len_wdata;
	logic [FILL_W-1:0]   fill_inc;
	logic                commit_remove;

	// frame byte offset within the record
	assign rd_off      = sent_q - SENT_W'(2);
	assign store_raddr = STORE_AW'(32'(head_q) * 32'(MAX_FRAME_BYTES) + 32'(rd_off));
	assign store_waddr = STORE_AW'(32'(tail_q) * 32'(MAX_FRAME_BYTES) + 32'(fill_q));
	assign fill_inc    = (fill_q <= MFB_FILL) ? fill_q + FILL_W'(1) : fill_q;
	assign len_wdata   = LEN_W'(fill_inc);

	ffrc_ram #(.WIDTH(8), .DEPTH(STORE_D)) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wdata (req_q.data_byte),
		.re    (cmd.lookup),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	ffrc_ram #(.WIDTH(LEN_W), .DEPTH(QUEUE_SLOTS)) u_lengths (
		.clk   (clk),
		.we    (len_we),
		.waddr (tail_q),
		.wdata (len_wdata),
		.re    (cmd.lookup),
		.raddr (head_q),
		.rdata (len_rdata)
	);

	always_comb begin
		head_d        = head_q;
		tail_d        = tail_q;
		fill_d        = fill_q;
		pending_d     = pending_q;
		rec_len_d     = rec_len_q;
		rec_cnt_d     = rec_cnt_q;
		sent_d        = sent_q;
		stat_inc      = '0;
		store_we      = 1'b0;
		len_we        = 1'b0;
		commit_remove = 1'b0;
		rsp_d         = '0;

		unique case (ffrc_pkg::req_code_t'(req_q.req_type))
			ffrc_pkg::REQ_PUBLISH: begin
				store_we = cmd.commit && (fill_q < MFB_FILL);
				fill_d   = fill_inc;
				if (req_q.frame_last) begin
					if (fill_inc > MFB_FILL) begin
						rsp_d.frame_dropped = 1'b1;
					end else if (slot_next(tail_q) == head_q) begin
						stat_inc[ffrc_pkg::STAT_DROPPED] = 1'b1;
						rsp_d.frame_dropped              = 1'b1;
					end else begin
						len_we                             = cmd.commit;
						tail_d                             = slot_next(tail_q);
						stat_inc[ffrc_pkg::STAT_PUBLISHED] = 1'b1;
						rsp_d.frame_accepted               = 1'b1;
					end
					fill_d = '0;
				end
			end
			ffrc_pkg::REQ_READ_START: begin
				stat_inc[ffrc_pkg::STAT_READ_REQ] = 1'b1;
				sent_d                            = '0;
				if (head_q != tail_q) begin
					rec_len_d = len_rdata;
					rec_cnt_d = occupancy(tail_q, head_q);
					pending_d = 1'b1;
				end else begin
					rec_len_d = '0;
					rec_cnt_d = '0;
					pending_d = 1'b0;
				end
			end
			ffrc_pkg::REQ_READ_BYTE: begin
				if (sent_q < RB_SENT) begin
					if (pending_q) begin
						priority if (sent_q == '0) begin
							rsp_d.tx_byte = 8'(rec_len_q);
						end else if (sent_q == SENT_W'(1)) begin
							rsp_d.tx_byte = 8'(rec_cnt_q);
						end else if (32'(rd_off) < 32'(rec_len_q)) begin
							rsp_d.tx_byte = store_rdata;
						end
					end
					sent_d = sent_q + SENT_W'(1);
				end
			end
			ffrc_pkg::REQ_READ_DONE: commit_remove = 1'b1;
			ffrc_pkg::REQ_BUS_ERROR: begin
				// nack after the whole frame went out still counts as read
				if (req_q.ack_failure && pending_q
						&& (32'(sent_q) >= 32'(rec_len_q) + 32'd2)) begin
					commit_remove = 1'b1;
				end else begin
					pending_d = 1'b0;
				end
				stat_inc[ffrc_pkg::STAT_BUS_ERR] = req_q.other_failure;
			end
			ffrc_pkg::REQ_WRITE_START: pending_d = 1'b0;
			ffrc_pkg::REQ_WRITE_DONE:  stat_inc[ffrc_pkg::STAT_CMD_WRITES] = 1'b1;
			ffrc_pkg::REQ_STAT_QUERY: begin
				if (32'(req_q.stat_select) < 32'(ffrc_pkg::NUM_STATS)) begin
					rsp_d.stat_value = stats_q[req_q.stat_select];
				end
			end
			default: ;
		endcase

		if (commit_remove) begin
			if (pending_q && (head_q != tail_q)) begin
				head_d                               = slot_next(head_q);
				stat_inc[ffrc_pkg::STAT_READ_FRAMES] = 1'b1;
				rsp_d.frame_consumed                 = 1'b1;
			end
			pending_d = 1'b0;
		end

		rsp_d.queue_level  = 5'(occupancy(tail_d, head_d));
		rsp_d.read_pending = pending_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			fill_q    <= '0;
			pending_q <= 1'b0;
			rec_len_q <= '0;
			rec_cnt_q <= '0;
			sent_q    <= '0;
			for (int i = 0; i < ffrc_pkg::NUM_STATS; i++) begin
				stats_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			head_q    <= head_d;
			tail_q    <= tail_d;
			fill_q    <= fill_d;
			pending_q <= pending_d;
			rec_len_q <= rec_len_d;
			rec_cnt_q <= rec_cnt_d;
			sent_q    <= sent_d;
			for (int i = 0; i < ffrc_pkg::NUM_STATS; i++) begin
				if (stat_inc[i]) begin
					stats_q[i] <= stats_q[i] + ffrc_pkg::STAT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_in;
		end
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_out = rsp_q;
endmodule
`default_nettype wire

/* rtl/core/frame_fifo_read_commit_mailbox_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// each accepted request word is captured, then steps through lookup and commit;
//   a new request word is taken only once the current one has committed, and the
//   frame and length memories get one access each per word
// the next request is taken while a response still waits in the output register
// reset: ring indexes, record state and statistics counters clear at once;
//   frame and length memories hold no reset value and need no clearing pass
// ----------------------------------------------------------------------------
// frame_fifo_read_commit_mailbox_core: frame ring mailbox with read commit
// producer publishes frames byte by byte; a bus master reads records and the
// head frame is dropped from the ring only when the read is committed
// ----------------------------------------------------------------------------
module frame_fifo_read_commit_mailbox_core #(
	parameter int QUEUE_SLOTS     = ffrc_pkg::QUEUE_SLOTS_DEF,
	parameter int MAX_FRAME_BYTES = ffrc_pkg::MAX_FRAME_BYTES_DEF,
	parameter int RECORD_BYTES    = ffrc_pkg::RECORD_BYTES_DEF
) (
	input wire logic     clk,
	input wire logic     arst_n,
	ffrc_chan_if.sink    req,
	ffrc_chan_if.source  rsp
);
	// command bundle from the sequencer into the datapath
	ffrc_pkg::cmd_t cmd;
	ffrc_pkg::rsp_t rsp_word;

	// controller: idle -> lookup (memory reads issued) -> commit (state update)
	// commit waits while the output register still holds an untaken word
	ffrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// datapath: ring pointers, record bookkeeping, statistics and memories
	ffrc_dpath #(
		.QUEUE_SLOTS     (QUEUE_SLOTS),
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES),
		.RECORD_BYTES    (RECORD_BYTES)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.req_in  (req.payload),
		.rsp_out (rsp_word)
	);

	// response word comes straight from the datapath output register
	assign rsp.payload = rsp_word;
endmodule
`default_nettype wire

/* tb/sv/tb_frame_fifo_read_commit_mailbox_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_fifo_read_commit_mailbox_core: frame ring mailbox testbench
// drives publish, bus read and statistics requests through the request channel
// and checks every response word against an in-bench model of the ring, the
// record read-out, the read commit and the statistics counters
// ----------------------------------------------------------------------------
module tb_frame_fifo_read_commit_mailbox_core;
	import ffrc_pkg::*;

	localparam int QS  = QUEUE_SLOTS_DEF;
	localparam int MFB = MAX_FRAME_BYTES_DEF;
	localparam int RB  = RECORD_BYTES_DEF;

	localparam int HALF_PERIOD = 5;
	// generous bound: every word with its longest gap, stall and block cycles, many times over
	localparam int RUN_LIMIT_NS = 2_000_000;

	// statistics select beyond the six counters, answers zero
	localparam logic [2:0] STAT_NONE = 3'd7;

	// how a bus read of one record is closed
	typedef enum int {
		END_DONE,
		END_NACK,
		END_FAULT,
		END_WRITE,
		END_OPEN
	} read_end_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ffrc_chan_if #(.PAYLOAD_T(req_t)) req_ch ();
	ffrc_chan_if #(.PAYLOAD_T(rsp_t)) rsp_ch ();

	frame_fifo_read_commit_mailbox_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------------
	// model of the mailbox: ring of frame slots, open record, counters
	// ------------------------------------------------------------------------
	logic [7:0]  frame_mem [QS * MFB];   // slot-major frame bytes
	int          slot_len  [QS];         // committed length per slot
	int          head_slot = 0;          // oldest frame
	int          tail_slot = 0;          // slot being filled
	int          fill_cnt  = 0;          // bytes seen in the frame being published
	bit          rec_live  = 1'b0;       // record carrying a frame is outstanding
	int          rec_len   = 0;
	int          rec_count = 0;
	int          sent_cnt  = 0;          // record bytes handed out so far
	logic [31:0] stats [NUM_STATS] = '{default: '0};

	// response words predicted for accepted requests, oldest first
	rsp_t replies_due [$];

	int  words_sent = 0;
	int  mismatches = 0;
	bit  sender_calm = 1'b0;
	bit  receiver_calm = 1'b0;

	function automatic int next_slot(int s);
		return (s + 1) % QS;
	endfunction

	function automatic int level();
		return (tail_slot + QS - head_slot) % QS;
	endfunction

	// remove the head frame if a record of it is outstanding; always ends the record
	function automatic bit commit_head();
		bit removed;
		removed = 1'b0;
		if (rec_live && head_slot != tail_slot) begin
			head_slot = next_slot(head_slot);
			stats[STAT_READ_FRAMES]++;
			removed = 1'b1;
		end
		rec_live = 1'b0;
		return removed;
	endfunction

	// advance the model by one request word and return the response it yields
	function automatic rsp_t compute_reply(req_t w);
		rsp_t r;
		r = '0;
		case (req_code_t'(w.req_type))
			REQ_PUBLISH: begin
				// bytes past the slot size are not stored, the count saturates one above
				if (fill_cnt < MFB)
					frame_mem[tail_slot * MFB + fill_cnt] = w.data_byte;
				if (fill_cnt <= MFB)
					fill_cnt++;
				if (w.frame_last) begin
					if (fill_cnt > MFB) begin
						// overlong frame: discarded, not counted
						r.frame_dropped = 1'b1;
					end else if (next_slot(tail_slot) == head_slot) begin
						// ring full: one slot always stays empty
						stats[STAT_DROPPED]++;
						r.frame_dropped = 1'b1;
					end else begin
						slot_len[tail_slot] = fill_cnt;
						tail_slot = next_slot(tail_slot);
						stats[STAT_PUBLISHED]++;
						r.frame_accepted = 1'b1;
					end
					fill_cnt = 0;
				end
			end
			REQ_READ_START: begin
				stats[STAT_READ_REQ]++;
				sent_cnt = 0;
				if (head_slot != tail_slot) begin
					rec_len = slot_len[head_slot];
					rec_count = level();
					rec_live = 1'b1;
				end else begin
					rec_len = 0;
					rec_count = 0;
					rec_live = 1'b0;
				end
			end
			REQ_READ_BYTE: begin
				// record layout: length, occupancy, frame bytes, zero padding
				if (sent_cnt < RB) begin
					if (rec_live) begin
						if (sent_cnt == 0)
							r.tx_byte = 8'(rec_len);
						else if (sent_cnt == 1)
							r.tx_byte = 8'(rec_count);
						else if (sent_cnt - 2 < rec_len)
							r.tx_byte = frame_mem[head_slot * MFB + sent_cnt - 2];
					end
					sent_cnt++;
				end
			end
			REQ_READ_DONE: begin
				r.frame_consumed = commit_head();
			end
			REQ_BUS_ERROR: begin
				// a nack after the whole frame went out still counts as a read
				if (w.ack_failure && rec_live) begin
					if (sent_cnt >= 2 + rec_len)
						r.frame_consumed = commit_head();
					else
						rec_live = 1'b0;
				end else begin
					rec_live = 1'b0;
				end
				if (w.other_failure)
					stats[STAT_BUS_ERR]++;
			end
			REQ_WRITE_START: begin
				rec_live = 1'b0;
			end
			REQ_WRITE_DONE: begin
				stats[STAT_CMD_WRITES]++;
			end
			default: begin
				if (w.stat_select < NUM_STATS)
					r.stat_value = stats[w.stat_select];
			end
		endcase
		r.queue_level = 5'(level());
		r.read_pending = rec_live;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------------

	// request word of the given kind with every other field random
	function automatic req_t make_word(req_code_t code);
		req_t w;
		w.req_type = code;
		w.data_byte = 8'($urandom);
		w.frame_last = 1'($urandom);
		w.ack_failure = 1'($urandom);
		w.other_failure = 1'($urandom);
		w.stat_select = 3'($urandom_range(0, 7));
		return w;
	endfunction

	// present one word after a random gap and hold it until taken
	task automatic send_word(req_t w);
		int gap;
		gap = sender_calm ? 0 : $urandom_range(0, 16);
		if ($urandom_range(0, 39) == 0)
			sender_calm = !sender_calm;
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.payload = w;
		req_ch.valid = 1'b1;
		do @(posedge clk); while (!req_ch.ready);
		replies_due.push_back(compute_reply(w));
		words_sent++;
	endtask

	task automatic publish_frame(int len);
		req_t w;
		for (int i = 0; i < len; i++) begin
			w = make_word(REQ_PUBLISH);
			w.frame_last = (i == len - 1);
			send_word(w);
		end
	endtask

	// read start, a number of read bytes, then the chosen close
	task automatic read_record(int nbytes, read_end_t how);
		req_t w;
		send_word(make_word(REQ_READ_START));
		repeat (nbytes) send_word(make_word(REQ_READ_BYTE));
		case (how)
			END_DONE: send_word(make_word(REQ_READ_DONE));
			END_NACK: begin
				w = make_word(REQ_BUS_ERROR);
				w.ack_failure = 1'b1;
				send_word(w);
			end
			END_FAULT: begin
				w = make_word(REQ_BUS_ERROR);
				w.ack_failure = 1'b0;
				w.other_failure = 1'b1;
				send_word(w);
			end
			END_WRITE: send_word(make_word(REQ_WRITE_START));
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------------
	// response side: random stalls, field by field compare
	// ------------------------------------------------------------------------
	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	initial begin : reply_checker
		rsp_t got;
		rsp_t want;
		int stall;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = receiver_calm ? 0 : $urandom_range(0, 16);
			if ($urandom_range(0, 39) == 0)
				receiver_calm = !receiver_calm;
			@(negedge clk);
			if (stall > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			got = rsp_ch.payload;
			if (replies_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected response word, expected none, actual %0h",
					$time, got);
			end else begin
				want = replies_due.pop_front();
				compare_field("tx_byte", want.tx_byte, got.tx_byte);
				compare_field("queue_level", want.queue_level, got.queue_level);
				compare_field("frame_accepted", want.frame_accepted, got.frame_accepted);
				compare_field("frame_dropped", want.frame_dropped, got.frame_dropped);
				compare_field("frame_consumed", want.frame_consumed, got.frame_consumed);
				compare_field("read_pending", want.read_pending, got.read_pending);
				compare_field("stat_value", want.stat_value, got.stat_value);
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// every request kind, byte extremes, reads with no record, early and late nack
	task automatic test_directed();
		req_t w;
		// read byte, read done and nack with nothing pending
		send_word(make_word(REQ_READ_BYTE));
		send_word(make_word(REQ_READ_DONE));
		w = make_word(REQ_BUS_ERROR);
		w.ack_failure = 1'b1;
		w.other_failure = 1'b1;
		send_word(w);
		// two-byte frame with extreme bytes, then a one-byte frame
		w = make_word(REQ_PUBLISH);
		w.data_byte = 8'h00;
		w.frame_last = 1'b0;
		send_word(w);
		w.data_byte = 8'hff;
		w.frame_last = 1'b1;
		send_word(w);
		w.data_byte = 8'ha5;
		send_word(w);
		// record of the first frame up to its last byte, committed by read done
		read_record(4, END_DONE);
		// nack before the frame went out only cancels
		read_record(1, END_NACK);
		// write start cancels, write done counts
		read_record(0, END_WRITE);
		send_word(make_word(REQ_WRITE_DONE));
		// nack together with another error right after the last frame byte
		read_record(3, END_OPEN);
		w = make_word(REQ_BUS_ERROR);
		w.ack_failure = 1'b1;
		w.other_failure = 1'b1;
		send_word(w);
		// statistics: first, last and an unused select
		w = make_word(REQ_STAT_QUERY);
		w.stat_select = STAT_PUBLISHED;
		send_word(w);
		w.stat_select = STAT_CMD_WRITES;
		send_word(w);
		w.stat_select = STAT_NONE;
		send_word(w);
	endtask

	// frame of the full slot size, read out past the end of the record
	task automatic test_full_record();
		publish_frame(MFB);
		read_record(RB + 3, END_DONE);
	endtask

	// overlong frames are discarded without touching the drop counter
	task automatic test_overlong();
		req_t w;
		publish_frame(MFB + 1);
		publish_frame(MFB + 8);
		w = make_word(REQ_STAT_QUERY);
		w.stat_select = STAT_DROPPED;
		send_word(w);
	endtask

	// fill the ring until frames drop, then take one frame out
	task automatic test_ring_full();
		req_t w;
		repeat (QS) publish_frame(1);
		w = make_word(REQ_STAT_QUERY);
		w.stat_select = STAT_DROPPED;
		send_word(w);
		read_record(3, END_DONE);
	endtask

	// well-formed publish and read sequences with random content, mixed with noise;
	// fill and drain phases swing the ring between empty and full
	task automatic test_random(int n_words);
		int stop_at;
		int pick;
		int span;
		int len;
		bit filling;
		read_end_t how;
		stop_at = words_sent + n_words;
		filling = 1'b1;
		while (words_sent < stop_at) begin
			if ($urandom_range(0, 11) == 0)
				filling = !filling;
			pick = $urandom_range(0, 99);
			if (pick < (filling ? 55 : 20)) begin
				// mostly short frames, some long, a few overlong
				len = $urandom_range(0, 19);
				if (len == 0)
					len = MFB + $urandom_range(1, 8);
				else if (len < 3)
					len = $urandom_range(9, MFB);
				else
					len = $urandom_range(1, 8);
				publish_frame(len);
			end else if (pick < 80) begin
				// aim around the end of the frame so a nack lands on both sides of it
				if (head_slot != tail_slot && $urandom_range(0, 3) != 0)
					span = 2 + slot_len[head_slot] + $urandom_range(0, 4) - 2;
				else
					span = $urandom_range(0, RB + 3);
				pick = $urandom_range(0, 9);
				if (pick < 5)
					how = END_DONE;
				else if (pick < 7)
					how = END_NACK;
				else if (pick == 7)
					how = END_FAULT;
				else if (pick == 8)
					how = END_WRITE;
				else
					how = END_OPEN;
				read_record(span, how);
			end else if (pick < 88) begin
				send_word(make_word(REQ_STAT_QUERY));
			end else if (pick < 92) begin
				send_word(make_word(REQ_WRITE_START));
				send_word(make_word(REQ_WRITE_DONE));
			end else begin
				// noise: any request with random fields, stray publish bytes included
				send_word(make_word(req_code_t'($urandom_range(0, 7))));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_full_record();
		test_overlong();
		test_ring_full();
		test_random(440);

		@(negedge clk);
		req_ch.valid = 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		// keep watching for any stray response word
		repeat (12) @(posedge clk);
		if (mismatches == 0 && replies_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#RUN_LIMIT_NS;
		$display("simulation failed");
		$finish;
	end

endmodule
